### rtl/core/i2c_register_access_master_macros.svh
// assertion helpers shared by the rtl
`ifndef I2C_REGISTER_ACCESS_MASTER_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_MACROS_SVH

// check on clk, disabled while in reset
`define I2CRA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check on clk, also active during reset
`define I2CRA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/i2cra_pkg.sv
`default_nettype none
package i2cra_pkg;

  // command codes carried in the mode field
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  // spare code, behaves as a plain tick
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_SETUP_TICKS    = 2'd1;
  localparam logic [1:0] CFG_PULSE_TICKS    = 2'd2;
  localparam logic [1:0] CFG_STOP_GAP_TICKS = 2'd3;

  // byte slots of a command
  localparam logic [2:0] BYTE_DEV_WR  = 3'd0;
  localparam logic [2:0] BYTE_REG     = 3'd1;
  localparam logic [2:0] BYTE_DATA_HI = 3'd2;
  localparam logic [2:0] BYTE_DATA_LO = 3'd3;
  localparam logic [2:0] BYTE_DEV_RD  = 3'd4;
  localparam logic [2:0] BYTE_RD_HI   = 3'd5;
  localparam logic [2:0] BYTE_RD_LO   = 3'd6;
  localparam logic [2:0] BIT_LAST     = 3'd7;

  // register reset values
  localparam logic [7:0] DEVICE_ADDRESS_RST = 8'd84;
  localparam logic [9:0] SETUP_TICKS_RST    = 10'd100;
  localparam logic [9:0] PULSE_TICKS_RST    = 10'd1;
  localparam logic [9:0] STOP_GAP_TICKS_RST = 10'd100;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_BIT_SETUP = 4'd3,
    PH_BIT_HIGH  = 4'd4,
    PH_BIT_LOW   = 4'd5,
    PH_ACK_SETUP = 4'd6,
    PH_ACK_HIGH  = 4'd7,
    PH_ACK_LOW   = 4'd8,
    PH_STOP_A    = 4'd9,
    PH_STOP_B    = 4'd10,
    PH_FREE      = 4'd11,
    PH_GAP       = 4'd12,
    PH_DONE      = 4'd13
  } phase_t;

  typedef struct packed {
    logic [7:0] device_address;
    logic [9:0] setup_ticks;
    logic [9:0] pulse_ticks;
    logic [9:0] stop_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  reg_addr;
    logic [15:0] write_word;
    logic        sda_in;
  } cmd_t;

  typedef struct packed {
    logic        scl;
    logic        sda_low;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_word;
    logic        ack_error;
  } res_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  bit_index;
    logic [2:0]  byte_index;
    logic [7:0]  shift_byte;
    logic [9:0]  tick_count;
    logic        is_read;
    logic [7:0]  held_reg_addr;
    logic [15:0] held_write_word;
    logic [15:0] read_value;
    logic        ack_fail;
  } seq_state_t;

endpackage
`default_nettype wire

### rtl/core/i2cra_if.sv
`default_nettype none
// command channel, one bus tick per transaction
interface i2cra_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  reg_addr;
  logic [15:0] write_word;
  logic        sda_in;
  modport source (output valid, mode, reg_addr, write_word, sda_in, input ready);
  modport sink (input valid, mode, reg_addr, write_word, sda_in, output ready);
endinterface

// result channel, one bus state per transaction
interface i2cra_res_if;
  logic        valid;
  logic        ready;
  logic        scl;
  logic        sda_low;
  logic        busy_res;
  logic        done_res;
  logic [15:0] read_word;
  logic        ack_error;
  modport source (output valid, scl, sda_low, busy_res, done_res, read_word, ack_error,
                  input ready);
  modport sink (input valid, scl, sda_low, busy_res, done_res, read_word, ack_error,
                output ready);
endinterface

// configuration write channel
interface i2cra_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/i2c_register_access_master.sv
// I2C master for 16-bit register access. Each command transaction is one bus tick; the
// block answers it with one result transaction carrying the SCL and SDA drive levels, busy,
// a one-tick done pulse, the last read value and a sticky acknowledge error. A mode of
// register write or read starts a command when the sequencer is idle and is ignored while
// busy. The sequencer state register is updated once per accepted tick by a single pass of
// next-state logic, and the bus levels land in a result register, so a new tick is accepted
// in every cycle in which the result register is empty or being drained. Phase lengths come
// from the configuration registers, which should be written only while no command is in
// progress.
`default_nettype none
module i2c_register_access_master (
  input  wire             clk,
  input  wire             rst,
  i2cra_cmd_if.sink       cmd,
  i2cra_res_if.source     res,
  i2cra_cfg_if.sink       cfg
);

  `include "i2c_register_access_master_macros.svh"

  i2cra_pkg::cfg_t       regs;
  i2cra_pkg::seq_state_t st;
  i2cra_pkg::seq_state_t st_next;
  i2cra_pkg::cmd_t       cmd_item;
  i2cra_pkg::res_t       res_next;
  i2cra_pkg::res_t       res_data;
  logic                  res_valid;
  logic                  cmd_take;

  // command payload into one struct
  assign cmd_item.mode       = cmd.mode;
  assign cmd_item.reg_addr   = cmd.reg_addr;
  assign cmd_item.write_word = cmd.write_word;
  assign cmd_item.sda_in     = cmd.sda_in;

  // accept while the result register is free or draining
  assign cmd.ready = !res_valid || res.ready;
  assign cmd_take  = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.device_address <= i2cra_pkg::DEVICE_ADDRESS_RST;
      regs.setup_ticks    <= i2cra_pkg::SETUP_TICKS_RST;
      regs.pulse_ticks    <= i2cra_pkg::PULSE_TICKS_RST;
      regs.stop_gap_ticks <= i2cra_pkg::STOP_GAP_TICKS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        i2cra_pkg::CFG_DEVICE_ADDRESS: regs.device_address <= cfg.data[7:0];
        i2cra_pkg::CFG_SETUP_TICKS:    regs.setup_ticks    <= cfg.data;
        i2cra_pkg::CFG_PULSE_TICKS:    regs.pulse_ticks    <= cfg.data;
        i2cra_pkg::CFG_STOP_GAP_TICKS: regs.stop_gap_ticks <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // bus sequencer step
  i2cra_seq u_seq (
    .cfg     (regs),
    .st      (st),
    .cmd     (cmd_item),
    .st_next (st_next),
    .res     (res_next)
  );

  // sequencer state, all zero is the idle phase
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (cmd_take) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_take) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      res_data <= res_next;
    end
  end

  assign res.valid     = res_valid;
  assign res.scl       = res_data.scl;
  assign res.sda_low   = res_data.sda_low;
  assign res.busy_res  = res_data.busy_res;
  assign res.done_res  = res_data.done_res;
  assign res.read_word = res_data.read_word;
  assign res.ack_error = res_data.ack_error;

  // checks
  `I2CRA_ASSERT(a_done_busy, res_valid && res_data.done_res |-> res_data.busy_res,
                "done raised outside a command")
  `I2CRA_ASSERT(a_idle_bus, res_valid && !res_data.busy_res |-> res_data.scl && !res_data.sda_low,
                "bus not released while idle")
  `I2CRA_ASSERT(a_ack_sticky, st.ack_fail |=> st.ack_fail,
                "ack error cleared without reset")

endmodule
`default_nettype wire

### rtl/core/i2cra_seq.sv
`default_nettype none
// one tick of the bus sequencer: next state and bus levels
module i2cra_seq (
  input  var i2cra_pkg::cfg_t       cfg,
  input  var i2cra_pkg::seq_state_t st,
  input  var i2cra_pkg::cmd_t       cmd,
  output i2cra_pkg::seq_state_t     st_next,
  output i2cra_pkg::res_t           res
);

  // byte sent in a given slot
  function automatic logic [7:0] byte_for(input i2cra_pkg::cfg_t c,
                                          input i2cra_pkg::seq_state_t s,
                                          input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      i2cra_pkg::BYTE_DEV_WR:  b = c.device_address;
      i2cra_pkg::BYTE_REG:     b = s.held_reg_addr;
      i2cra_pkg::BYTE_DATA_HI: b = s.held_write_word[15:8];
      i2cra_pkg::BYTE_DATA_LO: b = s.held_write_word[7:0];
      i2cra_pkg::BYTE_DEV_RD:  b = c.device_address + 8'd1;
      default:                 b = 8'd0;
    endcase
    return b;
  endfunction

  // start shifting the byte of a slot
  function automatic i2cra_pkg::seq_state_t begin_byte(input i2cra_pkg::cfg_t c,
                                                       input i2cra_pkg::seq_state_t s,
                                                       input logic [2:0] idx);
    i2cra_pkg::seq_state_t r;
    r            = s;
    r.byte_index = idx;
    r.shift_byte = byte_for(c, s, idx);
    r.bit_index  = 3'd0;
    r.phase      = i2cra_pkg::PH_BIT_SETUP;
    return r;
  endfunction

  i2cra_pkg::seq_state_t cur;
  i2cra_pkg::seq_state_t nxt;
  logic [9:0]            pulse_len;
  logic [9:0]            setup_len;
  logic [9:0]            gap_len;
  logic [9:0]            phase_len;
  logic                  recv;
  logic                  last;

  // command start from idle
  always_comb begin
    cur = st;
    if (st.phase == i2cra_pkg::PH_IDLE &&
        (cmd.mode == i2cra_pkg::MODE_WRITE || cmd.mode == i2cra_pkg::MODE_READ)) begin
      cur.held_reg_addr   = cmd.reg_addr;
      cur.held_write_word = cmd.write_word;
      cur.is_read         = (cmd.mode == i2cra_pkg::MODE_READ);
      cur.phase           = i2cra_pkg::PH_START_A;
      cur.tick_count      = 10'd0;
      cur.byte_index      = i2cra_pkg::BYTE_DEV_WR;
      cur.bit_index       = 3'd0;
      cur.shift_byte      = cfg.device_address;
    end
  end

  // phase length, zero counts as one tick
  always_comb begin
    pulse_len = (cfg.pulse_ticks == 10'd0) ? 10'd1 : cfg.pulse_ticks;
    setup_len = (cfg.setup_ticks == 10'd0) ? 10'd1 : cfg.setup_ticks;
    gap_len   = (cfg.stop_gap_ticks == 10'd0) ? 10'd1 : cfg.stop_gap_ticks;
    case (cur.phase)
      i2cra_pkg::PH_BIT_SETUP, i2cra_pkg::PH_ACK_SETUP: phase_len = setup_len;
      i2cra_pkg::PH_GAP:                               phase_len = gap_len;
      i2cra_pkg::PH_DONE:                              phase_len = 10'd1;
      default:                                         phase_len = pulse_len;
    endcase
    recv = (cur.byte_index == i2cra_pkg::BYTE_RD_HI) ||
           (cur.byte_index == i2cra_pkg::BYTE_RD_LO);
    last = ({1'b0, cur.tick_count} + 11'd1) >= {1'b0, phase_len};
  end

  // bus levels of this tick
  always_comb begin
    res          = '0;
    res.scl      = 1'b1;
    res.sda_low  = 1'b0;
    res.busy_res = (cur.phase != i2cra_pkg::PH_IDLE);
    case (cur.phase)
      i2cra_pkg::PH_START_A: begin
        res.sda_low = 1'b1;
      end
      i2cra_pkg::PH_START_B, i2cra_pkg::PH_STOP_A: begin
        res.scl     = 1'b0;
        res.sda_low = 1'b1;
      end
      i2cra_pkg::PH_STOP_B: begin
        res.sda_low = 1'b1;
      end
      i2cra_pkg::PH_BIT_SETUP, i2cra_pkg::PH_BIT_HIGH, i2cra_pkg::PH_BIT_LOW: begin
        res.scl     = (cur.phase == i2cra_pkg::PH_BIT_HIGH);
        res.sda_low = !recv && !cur.shift_byte[7];
      end
      i2cra_pkg::PH_ACK_SETUP, i2cra_pkg::PH_ACK_HIGH, i2cra_pkg::PH_ACK_LOW: begin
        res.scl     = (cur.phase == i2cra_pkg::PH_ACK_HIGH);
        res.sda_low = (cur.byte_index == i2cra_pkg::BYTE_RD_HI);
      end
      i2cra_pkg::PH_DONE: begin
        res.done_res = 1'b1;
      end
      default: begin
      end
    endcase
    res.read_word = nxt.read_value;
    res.ack_error = nxt.ack_fail;
  end

  // sampling and phase advance
  always_comb begin
    nxt = cur;
    if (cur.phase != i2cra_pkg::PH_IDLE) begin
      if (cur.phase == i2cra_pkg::PH_BIT_SETUP && last && recv) begin
        nxt.shift_byte = {cur.shift_byte[6:0], cmd.sda_in};
      end
      if (cur.phase == i2cra_pkg::PH_ACK_SETUP && last && !recv) begin
        nxt.ack_fail = cur.ack_fail | cmd.sda_in;
      end
      if (!last) begin
        nxt.tick_count = cur.tick_count + 10'd1;
      end else begin
        nxt.tick_count = 10'd0;
        case (cur.phase)
          i2cra_pkg::PH_START_A:   nxt.phase = i2cra_pkg::PH_START_B;
          i2cra_pkg::PH_START_B:   nxt = begin_byte(cfg, nxt, cur.byte_index);
          i2cra_pkg::PH_BIT_SETUP: nxt.phase = i2cra_pkg::PH_BIT_HIGH;
          i2cra_pkg::PH_BIT_HIGH:  nxt.phase = i2cra_pkg::PH_BIT_LOW;
          i2cra_pkg::PH_BIT_LOW: begin
            if (!recv) begin
              nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
            end
            if (cur.bit_index == i2cra_pkg::BIT_LAST) begin
              nxt.bit_index = 3'd0;
              if (cur.byte_index == i2cra_pkg::BYTE_RD_HI) begin
                nxt.read_value = {cur.shift_byte, cur.read_value[7:0]};
              end else if (cur.byte_index == i2cra_pkg::BYTE_RD_LO) begin
                nxt.read_value = {cur.read_value[15:8], cur.shift_byte};
              end
              nxt.phase = i2cra_pkg::PH_ACK_SETUP;
            end else begin
              nxt.bit_index = cur.bit_index + 3'd1;
              nxt.phase     = i2cra_pkg::PH_BIT_SETUP;
            end
          end
          i2cra_pkg::PH_ACK_SETUP: nxt.phase = i2cra_pkg::PH_ACK_HIGH;
          i2cra_pkg::PH_ACK_HIGH:  nxt.phase = i2cra_pkg::PH_ACK_LOW;
          i2cra_pkg::PH_ACK_LOW: begin
            if (cur.is_read) begin
              if (cur.byte_index == i2cra_pkg::BYTE_DEV_WR ||
                  cur.byte_index == i2cra_pkg::BYTE_DEV_RD ||
                  cur.byte_index == i2cra_pkg::BYTE_RD_HI) begin
                nxt = begin_byte(cfg, nxt, cur.byte_index + 3'd1);
              end else begin
                nxt.phase = i2cra_pkg::PH_STOP_A;
              end
            end else if (cur.byte_index < i2cra_pkg::BYTE_DATA_LO) begin
              nxt = begin_byte(cfg, nxt, cur.byte_index + 3'd1);
            end else begin
              nxt.phase = i2cra_pkg::PH_STOP_A;
            end
          end
          i2cra_pkg::PH_STOP_A: nxt.phase = i2cra_pkg::PH_STOP_B;
          i2cra_pkg::PH_STOP_B: begin
            if (cur.is_read && cur.byte_index == i2cra_pkg::BYTE_REG) begin
              nxt.phase = i2cra_pkg::PH_FREE;
            end else if (cfg.stop_gap_ticks != 10'd0) begin
              nxt.phase = i2cra_pkg::PH_GAP;
            end else begin
              nxt.phase = i2cra_pkg::PH_DONE;
            end
          end
          i2cra_pkg::PH_FREE: begin
            nxt.byte_index = i2cra_pkg::BYTE_DEV_RD;
            nxt.shift_byte = byte_for(cfg, cur, i2cra_pkg::BYTE_DEV_RD);
            nxt.phase      = i2cra_pkg::PH_START_A;
          end
          i2cra_pkg::PH_GAP: nxt.phase = i2cra_pkg::PH_DONE;
          default:           nxt.phase = i2cra_pkg::PH_IDLE;
        endcase
      end
    end
    st_next = nxt;
  end

endmodule
`default_nettype wire

### tb/sv/i2c_register_access_master_tb.sv
`default_nettype none
module i2c_register_access_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // longest stretch with no transaction on any channel: random gaps are short,
  // and so are the end wait and a config load
  localparam int QUIET_LIMIT = 4000;
  localparam int PRINT_LIMIT = 30;

  logic clk;
  logic rst;

  i2cra_cmd_if cmd_ch();
  i2cra_res_if res_ch();
  i2cra_cfg_if cfg_ch();

  i2c_register_access_master DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // stimulus and prediction state
  i2cra_pkg::cmd_t       tick_q[$];
  i2cra_pkg::res_t       bus_levels_q[$];
  i2cra_pkg::cfg_t       bus_cfg;
  i2cra_pkg::seq_state_t bus_state;
  i2cra_pkg::seq_state_t plan_state;
  i2cra_pkg::cmd_t       taken_cmd;
  i2cra_pkg::cmd_t       next_cmd;
  i2cra_pkg::res_t       taken_levels;
  i2cra_pkg::res_t       want_levels;
  int                    ticks_issued;
  int                    results_checked;
  int                    errors;
  int                    send_idle_pct;
  int                    recv_stall_pct;
  int                    quiet_cycles;

  // phase length in ticks, zero lengths count as one
  function automatic logic [9:0] phase_len(input i2cra_pkg::phase_t ph,
                                           input i2cra_pkg::cfg_t c);
    logic [9:0] p;
    logic [9:0] st;
    p  = (c.pulse_ticks != 10'd0) ? c.pulse_ticks : 10'd1;
    st = (c.setup_ticks != 10'd0) ? c.setup_ticks : 10'd1;
    if (ph == i2cra_pkg::PH_BIT_SETUP || ph == i2cra_pkg::PH_ACK_SETUP) return st;
    if (ph == i2cra_pkg::PH_GAP)
      return (c.stop_gap_ticks != 10'd0) ? c.stop_gap_ticks : 10'd1;
    if (ph == i2cra_pkg::PH_DONE) return 10'd1;
    return p;
  endfunction

  // byte sent in each slot of a command
  function automatic logic [7:0] slot_byte(input i2cra_pkg::seq_state_t s,
                                           input i2cra_pkg::cfg_t c,
                                           input logic [2:0] idx);
    case (idx)
      i2cra_pkg::BYTE_DEV_WR:  return c.device_address;
      i2cra_pkg::BYTE_REG:     return s.held_reg_addr;
      i2cra_pkg::BYTE_DATA_HI: return s.held_write_word[15:8];
      i2cra_pkg::BYTE_DATA_LO: return s.held_write_word[7:0];
      i2cra_pkg::BYTE_DEV_RD:  return c.device_address + 8'd1;
      default:                 return 8'd0;
    endcase
  endfunction

  function automatic void load_byte(inout i2cra_pkg::seq_state_t s,
                                    input i2cra_pkg::cfg_t c, input logic [2:0] idx);
    s.byte_index = idx;
    s.shift_byte = slot_byte(s, c, idx);
    s.bit_index  = 3'd0;
    s.phase      = i2cra_pkg::PH_BIT_SETUP;
  endfunction

  // advance the sequencer by one tick and return the bus levels it drives
  function automatic void bus_tick(inout i2cra_pkg::seq_state_t s,
                                   input i2cra_pkg::cfg_t c, input i2cra_pkg::cmd_t t,
                                   output i2cra_pkg::res_t r);
    logic recv;
    logic last;
    r = '0;
    r.scl = 1'b1;
    if (s.phase == i2cra_pkg::PH_IDLE || s.phase > i2cra_pkg::PH_DONE) begin
      s.phase = i2cra_pkg::PH_IDLE;
      if (t.mode == i2cra_pkg::MODE_WRITE || t.mode == i2cra_pkg::MODE_READ) begin
        s.held_reg_addr   = t.reg_addr;
        s.held_write_word = t.write_word;
        s.is_read         = (t.mode == i2cra_pkg::MODE_READ);
        s.phase           = i2cra_pkg::PH_START_A;
        s.tick_count      = 10'd0;
        s.byte_index      = i2cra_pkg::BYTE_DEV_WR;
        s.bit_index       = 3'd0;
        s.shift_byte      = c.device_address;
      end
    end

    if (s.phase != i2cra_pkg::PH_IDLE) begin
      recv = (s.byte_index == i2cra_pkg::BYTE_RD_HI || s.byte_index == i2cra_pkg::BYTE_RD_LO);
      last = ({1'b0, s.tick_count} + 11'd1) >= {1'b0, phase_len(s.phase, c)};
      r.busy_res = 1'b1;
      // bus levels of the current phase
      case (s.phase)
        i2cra_pkg::PH_START_A: begin r.scl = 1'b1; r.sda_low = 1'b1; end
        i2cra_pkg::PH_START_B: begin r.scl = 1'b0; r.sda_low = 1'b1; end
        i2cra_pkg::PH_BIT_SETUP, i2cra_pkg::PH_BIT_HIGH, i2cra_pkg::PH_BIT_LOW: begin
          r.scl     = (s.phase == i2cra_pkg::PH_BIT_HIGH);
          r.sda_low = recv ? 1'b0 : ~s.shift_byte[7];
        end
        i2cra_pkg::PH_ACK_SETUP, i2cra_pkg::PH_ACK_HIGH, i2cra_pkg::PH_ACK_LOW: begin
          r.scl     = (s.phase == i2cra_pkg::PH_ACK_HIGH);
          r.sda_low = (s.byte_index == i2cra_pkg::BYTE_RD_HI);
        end
        i2cra_pkg::PH_STOP_A: begin r.scl = 1'b0; r.sda_low = 1'b1; end
        i2cra_pkg::PH_STOP_B: begin r.scl = 1'b1; r.sda_low = 1'b1; end
        i2cra_pkg::PH_DONE:   r.done_res = 1'b1;
        default: ;
      endcase

      // sample on the last setup tick
      if (s.phase == i2cra_pkg::PH_BIT_SETUP && last && recv)
        s.shift_byte = {s.shift_byte[6:0], t.sda_in};
      if (s.phase == i2cra_pkg::PH_ACK_SETUP && last && !recv)
        s.ack_fail = s.ack_fail | t.sda_in;

      if (!last) begin
        s.tick_count = s.tick_count + 10'd1;
      end else begin
        s.tick_count = 10'd0;
        case (s.phase)
          i2cra_pkg::PH_START_A:   s.phase = i2cra_pkg::PH_START_B;
          i2cra_pkg::PH_START_B:   load_byte(s, c, s.byte_index);
          i2cra_pkg::PH_BIT_SETUP: s.phase = i2cra_pkg::PH_BIT_HIGH;
          i2cra_pkg::PH_BIT_HIGH:  s.phase = i2cra_pkg::PH_BIT_LOW;
          i2cra_pkg::PH_BIT_LOW: begin
            if (!recv) s.shift_byte = {s.shift_byte[6:0], 1'b0};
            if (s.bit_index >= i2cra_pkg::BIT_LAST) begin
              s.bit_index = 3'd0;
              if (s.byte_index == i2cra_pkg::BYTE_RD_HI)
                s.read_value[15:8] = s.shift_byte;
              else if (s.byte_index == i2cra_pkg::BYTE_RD_LO)
                s.read_value[7:0] = s.shift_byte;
              s.phase = i2cra_pkg::PH_ACK_SETUP;
            end else begin
              s.bit_index = s.bit_index + 3'd1;
              s.phase = i2cra_pkg::PH_BIT_SETUP;
            end
          end
          i2cra_pkg::PH_ACK_SETUP: s.phase = i2cra_pkg::PH_ACK_HIGH;
          i2cra_pkg::PH_ACK_HIGH:  s.phase = i2cra_pkg::PH_ACK_LOW;
          i2cra_pkg::PH_ACK_LOW: begin
            if (s.is_read) begin
              if (s.byte_index == i2cra_pkg::BYTE_DEV_WR ||
                  s.byte_index == i2cra_pkg::BYTE_DEV_RD ||
                  s.byte_index == i2cra_pkg::BYTE_RD_HI)
                load_byte(s, c, s.byte_index + 3'd1);
              else
                s.phase = i2cra_pkg::PH_STOP_A;
            end else begin
              if (s.byte_index < i2cra_pkg::BYTE_DATA_LO)
                load_byte(s, c, s.byte_index + 3'd1);
              else
                s.phase = i2cra_pkg::PH_STOP_A;
            end
          end
          i2cra_pkg::PH_STOP_A: s.phase = i2cra_pkg::PH_STOP_B;
          i2cra_pkg::PH_STOP_B: begin
            if (s.is_read && s.byte_index == i2cra_pkg::BYTE_REG)
              s.phase = i2cra_pkg::PH_FREE;
            else if (c.stop_gap_ticks != 10'd0)
              s.phase = i2cra_pkg::PH_GAP;
            else
              s.phase = i2cra_pkg::PH_DONE;
          end
          i2cra_pkg::PH_FREE: begin
            s.byte_index = i2cra_pkg::BYTE_DEV_RD;
            s.shift_byte = slot_byte(s, c, i2cra_pkg::BYTE_DEV_RD);
            s.phase      = i2cra_pkg::PH_START_A;
          end
          i2cra_pkg::PH_GAP: s.phase = i2cra_pkg::PH_DONE;
          default:           s.phase = i2cra_pkg::PH_IDLE;
        endcase
      end
    end
    r.read_word = s.read_value;
    r.ack_error = s.ack_fail;
  endfunction

  function automatic i2cra_pkg::cfg_t timing(input logic [7:0] dev, input logic [9:0] setup,
                                             input logic [9:0] pulse, input logic [9:0] gap);
    i2cra_pkg::cfg_t c;
    c.device_address = dev;
    c.setup_ticks    = setup;
    c.pulse_ticks    = pulse;
    c.stop_gap_ticks = gap;
    return c;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // command driver, prediction taken on each accepted tick
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        taken_cmd.mode       = cmd_ch.mode;
        taken_cmd.reg_addr   = cmd_ch.reg_addr;
        taken_cmd.write_word = cmd_ch.write_word;
        taken_cmd.sda_in     = cmd_ch.sda_in;
        bus_tick(bus_state, bus_cfg, taken_cmd, taken_levels);
        bus_levels_q.push_back(taken_levels);
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_cmd = tick_q.pop_front();
          cmd_ch.valid      <= 1'b1;
          cmd_ch.mode       <= next_cmd.mode;
          cmd_ch.reg_addr   <= next_cmd.reg_addr;
          cmd_ch.write_word <= next_cmd.write_word;
          cmd_ch.sda_in     <= next_cmd.sda_in;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_checked++;
        if (bus_levels_q.size() == 0) begin
          errors++;
          if (errors <= PRINT_LIMIT)
            $display("%0t: result transaction with no tick pending, expected none actual %0h",
                     $time, res_ch.read_word);
        end else begin
          want_levels = bus_levels_q.pop_front();
          check_field("scl", 16'(want_levels.scl), 16'(res_ch.scl));
          check_field("sda_low", 16'(want_levels.sda_low), 16'(res_ch.sda_low));
          check_field("busy_res", 16'(want_levels.busy_res), 16'(res_ch.busy_res));
          check_field("done_res", 16'(want_levels.done_res), 16'(res_ch.done_res));
          check_field("read_word", want_levels.read_word, res_ch.read_word);
          check_field("ack_error", 16'(want_levels.ack_error), 16'(res_ch.ack_error));
        end
      end
      res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog on channel activity
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || rst)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // queue one tick and track where the bus will be
  task automatic queue_tick(input i2cra_pkg::cmd_t c);
    i2cra_pkg::res_t unused;
    bus_tick(plan_state, bus_cfg, c, unused);
    tick_q.push_back(c);
    ticks_issued++;
  endtask

  // slave answers: ack low unless a nack is wanted, anything else random
  function automatic logic pick_sda(input int nack_pct);
    if (plan_state.phase == i2cra_pkg::PH_ACK_SETUP &&
        plan_state.byte_index != i2cra_pkg::BYTE_RD_HI &&
        plan_state.byte_index != i2cra_pkg::BYTE_RD_LO)
      return (nack_pct != 0) && ($urandom_range(1, 100) <= nack_pct);
    return 1'($urandom_range(0, 1));
  endfunction

  // one command from start to done, with stray starts while busy
  task automatic run_command(input logic [1:0] mode, input logic [7:0] reg_addr,
                             input logic [15:0] data, input int nack_pct);
    i2cra_pkg::cmd_t c;
    c.mode       = mode;
    c.reg_addr   = reg_addr;
    c.write_word = data;
    c.sda_in     = pick_sda(nack_pct);
    queue_tick(c);
    while (plan_state.phase != i2cra_pkg::PH_IDLE) begin
      if ($urandom_range(0, 99) < 4)
        c.mode = $urandom_range(0, 1) ? i2cra_pkg::MODE_WRITE : i2cra_pkg::MODE_READ;
      else
        c.mode = i2cra_pkg::MODE_TICK;
      c.reg_addr   = 8'($urandom);
      c.write_word = 16'($urandom);
      c.sda_in     = pick_sda(nack_pct);
      queue_tick(c);
    end
    // a few idle bus ticks, spare mode code included
    repeat ($urandom_range(0, 3)) begin
      c.mode       = $urandom_range(0, 1) ? i2cra_pkg::MODE_TICK : i2cra_pkg::MODE_UNUSED;
      c.reg_addr   = 8'($urandom);
      c.write_word = 16'($urandom);
      c.sda_in     = 1'($urandom_range(0, 1));
      queue_tick(c);
    end
  endtask

  // wait until every queued tick has returned its result
  task automatic settle();
    while (results_checked != ticks_issued) @(posedge clk);
  endtask

  // write all four configuration registers, block idle
  task automatic load_timing(input i2cra_pkg::cfg_t c);
    logic [1:0] idx;
    logic [9:0] val;
    @(posedge clk);
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: begin idx = i2cra_pkg::CFG_DEVICE_ADDRESS; val = {2'b00, c.device_address}; end
        1: begin idx = i2cra_pkg::CFG_SETUP_TICKS;    val = c.setup_ticks; end
        2: begin idx = i2cra_pkg::CFG_PULSE_TICKS;    val = c.pulse_ticks; end
        default: begin idx = i2cra_pkg::CFG_STOP_GAP_TICKS; val = c.stop_gap_ticks; end
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= val;
      do @(posedge clk); while (!cfg_ch.ready);
      case (idx)
        i2cra_pkg::CFG_DEVICE_ADDRESS: bus_cfg.device_address = val[7:0];
        i2cra_pkg::CFG_SETUP_TICKS:    bus_cfg.setup_ticks = val;
        i2cra_pkg::CFG_PULSE_TICKS:    bus_cfg.pulse_ticks = val;
        default:                       bus_cfg.stop_gap_ticks = val;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // reset, directed command, random commands, final check
  initial begin
    i2cra_pkg::cmd_t c;
    rst                = 1'b1;
    cmd_ch.valid       = 1'b0;
    cmd_ch.mode        = i2cra_pkg::MODE_TICK;
    cmd_ch.reg_addr    = 8'd0;
    cmd_ch.write_word  = 16'd0;
    cmd_ch.sda_in      = 1'b0;
    res_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = i2cra_pkg::CFG_DEVICE_ADDRESS;
    cfg_ch.data        = 10'd0;
    bus_cfg            = timing(i2cra_pkg::DEVICE_ADDRESS_RST, i2cra_pkg::SETUP_TICKS_RST,
                                i2cra_pkg::PULSE_TICKS_RST, i2cra_pkg::STOP_GAP_TICKS_RST);
    bus_state          = '0;
    plan_state         = '0;
    ticks_issued       = 0;
    results_checked    = 0;
    errors             = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    quiet_cycles       = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle bus ticks, spare mode code included
    for (int k = 0; k < 4; k++) begin
      c.mode       = k[0] ? i2cra_pkg::MODE_UNUSED : i2cra_pkg::MODE_TICK;
      c.reg_addr   = 8'($urandom);
      c.write_word = 16'($urandom);
      c.sda_in     = k[1];
      queue_tick(c);
    end
    settle();

    // read at device address 254, setup of two ticks, no stop gap
    load_timing(timing(8'd254, 10'd2, 10'd1, 10'd0));
    run_command(i2cra_pkg::MODE_READ, 8'hA5, 16'hFFFF, 0);

    // one command under each idling pattern, nacks only at the end
    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      load_timing(timing(8'($urandom_range(0, 254)), 10'd1, 10'd1,
                         10'($urandom_range(0, 3))));
      run_command((p % 2 == 0) ? i2cra_pkg::MODE_WRITE : i2cra_pkg::MODE_READ,
                  8'($urandom), 16'($urandom), (p == 3) ? 25 : 0);
    end

    settle();
    repeat (8) @(posedge clk);
    if (bus_levels_q.size() != 0) begin
      errors++;
      $display("%0t: results left over, expected 0 actual %0d", $time, bus_levels_q.size());
    end
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
